// ===== design/ps2mt_pkg.sv =====
// shared types, constants and codes for the ps2 mouse packet tracker
`default_nettype none
package ps2mt_pkg;

  localparam int POS_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int BYTE_W   = 8;
  localparam int BTN_W    = 3;
  localparam int DELTA_W  = BYTE_W + 2;
  localparam int CALC_W   = SIZE_W + 2;
  localparam int CFG_IDX_W = 1;

  localparam int CURSOR_EXTENT = 12;
  localparam int POS_MAX       = (1 << POS_W) - 1;

  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RESET = SIZE_W'(768);

  // header bit positions
  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;
  localparam int HDR_XOVF_BIT = 6;
  localparam int HDR_YOVF_BIT = 7;

  localparam logic OP_BYTE     = 1'b0;
  localparam logic OP_RECENTER = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  typedef struct packed {
    logic              packet_done;
    logic              packet_dropped;
    logic              sync_rejected;
    logic [POS_W-1:0]  cursor_x;
    logic [POS_W-1:0]  cursor_y;
    logic [BTN_W-1:0]  buttons;
  } result_t;

endpackage
`default_nettype wire

// ===== design/ps2mt_axis.sv =====
// one axis of cursor movement: add a delta and clamp to the screen
`default_nettype none
module ps2mt_axis
  import ps2mt_pkg::*;
(
  input  wire logic [POS_W-1:0]         pos,
  input  wire logic signed [DELTA_W-1:0] delta,
  input  wire logic [SIZE_W-1:0]        size,
  output logic [POS_W-1:0]              pos_new
);

  logic signed [CALC_W-1:0] sum;
  logic signed [CALC_W-1:0] lim;
  logic signed [CALC_W-1:0] low_clamped;
  logic signed [CALC_W-1:0] high_clamped;
  logic signed [CALC_W-1:0] floored;

  always_comb begin
    sum = $signed({{(CALC_W-POS_W){1'b0}}, pos}) + CALC_W'(delta);
    lim = $signed({{(CALC_W-SIZE_W){1'b0}}, size}) - CALC_W'(CURSOR_EXTENT);
    low_clamped = (sum < 0) ? '0 : sum;
    high_clamped = (low_clamped >= lim) ? (lim - CALC_W'(1)) : low_clamped;
    // small screens can push the limit below zero
    floored = (high_clamped < 0) ? '0 : high_clamped;
    if (floored > CALC_W'(POS_MAX)) begin
      pos_new = POS_W'(POS_MAX);
    end else begin
      pos_new = floored[POS_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/ps2_mouse_packet_tracker_unit.sv =====
// top level: ps2 mouse packet assembly, cursor tracking and result buffering
`default_nettype none
// Takes one mouse byte or recenter request per transaction and returns exactly one
// result per transaction. An item is accepted every cycle as long as the result side
// keeps up: the packet state and cursor update in the accepting cycle and the result
// appears in the output register on the next cycle. A skid
// register behind the output register lets one more transaction in while a result is
// stalled; input ready drops only when both are full. Headers must have bit 3 set,
// otherwise the byte is flagged as a sync reject. Packets with an overflow bit are
// flagged as dropped and leave cursor and buttons unchanged. Configuration writes
// (screen width, screen height) are always ready and take effect on the next item.
module ps2_mouse_packet_tracker_unit
  import ps2mt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [SIZE_W-1:0]     cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  op,
  input  wire logic [BYTE_W-1:0]     rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       packet_done,
  output logic                       packet_dropped,
  output logic                       sync_rejected,
  output logic [POS_W-1:0]           cursor_x,
  output logic [POS_W-1:0]           cursor_y,
  output logic [BTN_W-1:0]           buttons
);

  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;

  phase_t            byte_phase, byte_phase_next;
  logic [BYTE_W-1:0] header_byte, header_byte_next;
  logic [BYTE_W-1:0] x_byte, x_byte_next;
  logic [POS_W-1:0]  pos_x, pos_x_next;
  logic [POS_W-1:0]  pos_y, pos_y_next;
  logic [BTN_W-1:0]  button_bits, button_bits_next;

  logic done, dropped, rejected;
  logic in_accept;

  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy_neg;
  logic [POS_W-1:0] moved_x;
  logic [POS_W-1:0] moved_y;

  result_t result_new;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // 10-bit deltas from the header sign bits, y negated since screen rows grow downward
  assign dx = $signed({header_byte[HDR_XSIGN_BIT], header_byte[HDR_XSIGN_BIT], x_byte});
  assign dy_neg = -$signed({header_byte[HDR_YSIGN_BIT], header_byte[HDR_YSIGN_BIT],
                            rx_byte});

  ps2mt_axis u_axis_x (
    .pos     (pos_x),
    .delta   (dx),
    .size    (screen_width),
    .pos_new (moved_x)
  );

  ps2mt_axis u_axis_y (
    .pos     (pos_y),
    .delta   (dy_neg),
    .size    (screen_height),
    .pos_new (moved_y)
  );

  // next state
  always_comb begin
    byte_phase_next  = byte_phase;
    header_byte_next = header_byte;
    x_byte_next      = x_byte;
    pos_x_next       = pos_x;
    pos_y_next       = pos_y;
    button_bits_next = button_bits;
    if (op == OP_RECENTER) begin
      pos_x_next = screen_width[SIZE_W-1:1];
      pos_y_next = screen_height[SIZE_W-1:1];
    end else begin
      case (byte_phase)
        PH_X: begin
          x_byte_next     = rx_byte;
          byte_phase_next = PH_Y;
        end
        PH_Y: begin
          if (!header_byte[HDR_XOVF_BIT] && !header_byte[HDR_YOVF_BIT]) begin
            button_bits_next = header_byte[BTN_W-1:0];
            pos_x_next       = moved_x;
            pos_y_next       = moved_y;
          end
          byte_phase_next = PH_HEADER;
        end
        default: begin
          if (rx_byte[HDR_SYNC_BIT]) begin
            header_byte_next = rx_byte;
            byte_phase_next  = PH_X;
          end else begin
            byte_phase_next = PH_HEADER;
          end
        end
      endcase
    end
  end

  // result flags
  always_comb begin
    done     = 1'b0;
    dropped  = 1'b0;
    rejected = 1'b0;
    if (op == OP_BYTE) begin
      case (byte_phase)
        PH_X: ;
        PH_Y: begin
          if (header_byte[HDR_XOVF_BIT] || header_byte[HDR_YOVF_BIT]) begin
            dropped = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
        default: rejected = !rx_byte[HDR_SYNC_BIT];
      endcase
    end
  end

  always_comb begin
    result_new.packet_done    = done;
    result_new.packet_dropped = dropped;
    result_new.sync_rejected  = rejected;
    result_new.cursor_x       = pos_x_next;
    result_new.cursor_y       = pos_y_next;
    result_new.buttons        = button_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= PH_HEADER;
      header_byte <= '0;
      x_byte      <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      button_bits <= '0;
    end else if (in_accept) begin
      byte_phase  <= byte_phase_next;
      header_byte <= header_byte_next;
      x_byte      <= x_byte_next;
      pos_x       <= pos_x_next;
      pos_y       <= pos_y_next;
      button_bits <= button_bits_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_accept) begin
        out_reg <= result_new;
      end
    end else if (in_accept) begin
      skid_reg <= result_new;
    end
  end

  assign packet_done    = out_reg.packet_done;
  assign packet_dropped = out_reg.packet_dropped;
  assign sync_rejected  = out_reg.sync_rejected;
  assign cursor_x       = out_reg.cursor_x;
  assign cursor_y       = out_reg.cursor_y;
  assign buttons        = out_reg.buttons;

endmodule
`default_nettype wire

// ===== tb/ps2_mouse_packet_tracker_unit_tb.sv =====
// testbench for the ps2 mouse packet tracker: directed table, random packets, scoreboard
module ps2_mouse_packet_tracker_unit_tb;
  import ps2mt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DIR_N       = 25;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    logic              op_v;
    logic [BYTE_W-1:0] data;
    bit                fixed;
    result_t           want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 op;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 packet_done;
  logic                 packet_dropped;
  logic                 sync_rejected;
  logic [POS_W-1:0]     cursor_x;
  logic [POS_W-1:0]     cursor_y;
  logic [BTN_W-1:0]     buttons;

  // typed expectation travels with the payload of a directed row
  logic    row_fixed;
  result_t row_want;

  logic recv_ready;
  logic long_stall;
  bit   hold_req;
  bit   send_idle_on;
  bit   recv_idle_on;
  bit   burst_on;
  bit   drift_x;
  bit   drift_y;
  int   items_sent;
  int   fail_count;
  int   cycle_cnt;

  // tracker copy kept by the testbench
  phase_t            trk_phase;
  logic [BYTE_W-1:0] trk_header;
  logic [BYTE_W-1:0] trk_xmove;
  logic [POS_W-1:0]  trk_col;
  logic [POS_W-1:0]  trk_row;
  logic [BTN_W-1:0]  trk_btn;
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  result_t pending_reports[$];

  stim_row_t dir_rows [DIR_N] = '{
    '{OP_BYTE,     8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 12'd0,   12'd0,   3'd0}},
    '{OP_BYTE,     8'hF7, 1'b1, '{1'b0, 1'b0, 1'b1, 12'd0,   12'd0,   3'd0}},
    '{OP_RECENTER, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 12'd512, 12'd384, 3'd0}},
    '{OP_BYTE,     8'h0F, 1'b1, '{1'b0, 1'b0, 1'b0, 12'd512, 12'd384, 3'd0}},
    '{OP_BYTE,     8'hFF, 1'b1, '{1'b0, 1'b0, 1'b0, 12'd512, 12'd384, 3'd0}},
    '{OP_BYTE,     8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 12'd767, 12'd384, 3'd7}},
    '{OP_BYTE,     8'h38, 1'b0, '0},
    '{OP_BYTE,     8'h00, 1'b0, '0},
    '{OP_BYTE,     8'h00, 1'b0, '0},
    '{OP_BYTE,     8'h48, 1'b0, '0},
    '{OP_BYTE,     8'h12, 1'b0, '0},
    '{OP_BYTE,     8'h34, 1'b1, '{1'b0, 1'b1, 1'b0, 12'd511, 12'd640, 3'd0}},
    '{OP_BYTE,     8'hFF, 1'b0, '0},
    '{OP_BYTE,     8'hFF, 1'b0, '0},
    '{OP_BYTE,     8'hFF, 1'b0, '0},
    '{OP_BYTE,     8'h08, 1'b0, '0},
    '{OP_BYTE,     8'hFF, 1'b0, '0},
    '{OP_BYTE,     8'h80, 1'b0, '0},
    '{OP_BYTE,     8'h1C, 1'b0, '0},
    '{OP_BYTE,     8'h01, 1'b0, '0},
    '{OP_BYTE,     8'hFF, 1'b0, '0},
    '{OP_BYTE,     8'h0A, 1'b0, '0},
    '{OP_RECENTER, 8'h00, 1'b0, '0},
    '{OP_BYTE,     8'h05, 1'b0, '0},
    '{OP_BYTE,     8'h05, 1'b0, '0}
  };

  assign out_ready = recv_ready && !long_stall;

  ps2_mouse_packet_tracker_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .packet_done    (packet_done),
    .packet_dropped (packet_dropped),
    .sync_rejected  (sync_rejected),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .buttons        (buttons)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [POS_W-1:0] clamp_axis(input logic [POS_W-1:0] pos,
                                                  input int delta,
                                                  input logic [SIZE_W-1:0] size);
    int p;
    int lim;
    p   = int'(pos) + delta;
    lim = int'(size) - CURSOR_EXTENT;
    if (p < 0) p = 0;
    if (p >= lim) p = lim - 1;
    if (p < 0) p = 0;
    if (p > POS_MAX) p = POS_MAX;
    return p[POS_W-1:0];
  endfunction

  function automatic result_t advance_tracker(input logic op_i, input logic [BYTE_W-1:0] b);
    result_t r;
    int      dx;
    int      dy;
    r = '0;
    if (op_i == OP_RECENTER) begin
      trk_col = POS_W'(scr_w >> 1);
      trk_row = POS_W'(scr_h >> 1);
    end else begin
      case (trk_phase)
        PH_X: begin
          trk_xmove = b;
          trk_phase = PH_Y;
        end
        PH_Y: begin
          dx = int'(trk_xmove) - (trk_header[HDR_XSIGN_BIT] ? (1 << BYTE_W) : 0);
          dy = int'(b) - (trk_header[HDR_YSIGN_BIT] ? (1 << BYTE_W) : 0);
          if (trk_header[HDR_XOVF_BIT] || trk_header[HDR_YOVF_BIT]) begin
            r.packet_dropped = 1'b1;
          end else begin
            trk_btn = trk_header[BTN_W-1:0];
            trk_col = clamp_axis(trk_col, dx, scr_w);
            // screen rows grow downward
            trk_row = clamp_axis(trk_row, -dy, scr_h);
            r.packet_done = 1'b1;
          end
          trk_phase = PH_HEADER;
        end
        default: begin
          // the header phase, and any unreachable phase value, use header handling
          if (b[HDR_SYNC_BIT]) begin
            trk_header = b;
            trk_phase  = PH_X;
          end else begin
            r.sync_rejected = 1'b1;
            trk_phase       = PH_HEADER;
          end
        end
      endcase
    end
    r.cursor_x = trk_col;
    r.cursor_y = trk_row;
    r.buttons  = trk_btn;
    return r;
  endfunction

  // prediction on input transactions, comparison on output transactions
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t pred;
    if (rst) begin
      trk_phase  = PH_HEADER;
      trk_header = '0;
      trk_xmove  = '0;
      trk_col    = '0;
      trk_row    = '0;
      trk_btn    = '0;
      scr_w      = SCREEN_WIDTH_RESET;
      scr_h      = SCREEN_HEIGHT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w = cfg_data;
          REG_SCREEN_HEIGHT: scr_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred = advance_tracker(op, rx_byte);
        pending_reports.push_back(row_fixed ? row_want : pred);
      end
      if (out_valid && out_ready) begin
        got = '{packet_done, packet_dropped, sync_rejected, cursor_x, cursor_y, buttons};
        if (pending_reports.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: done=%0d drop=%0d rej=%0d x=%0d y=%0d btn=%0d",
                     got.packet_done, got.packet_dropped, got.sync_rejected,
                     got.cursor_x, got.cursor_y, got.buttons);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (got.packet_done !== want.packet_done ||
              got.packet_dropped !== want.packet_dropped ||
              got.sync_rejected !== want.sync_rejected ||
              got.cursor_x !== want.cursor_x ||
              got.cursor_y !== want.cursor_y ||
              got.buttons !== want.buttons) begin
            if (fail_count < 10) begin
              $display("mismatch want: done=%0d drop=%0d rej=%0d x=%0d y=%0d btn=%0d",
                       want.packet_done, want.packet_dropped, want.sync_rejected,
                       want.cursor_x, want.cursor_y, want.buttons);
              $display("         got:  done=%0d drop=%0d rej=%0d x=%0d y=%0d btn=%0d",
                       got.packet_done, got.packet_dropped, got.sync_rejected,
                       got.cursor_x, got.cursor_y, got.buttons);
            end
            fail_count++;
          end
        end
      end
    end
  end

  // result side: random per-transaction delay while result idle gaps are on
  initial begin
    int gap;
    recv_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = recv_idle_on ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
        recv_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      recv_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // long hold-off of the result side, counted here
  initial begin
    long_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        long_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("** ps2_mouse_packet_tracker_unit: FAILED **");
    $finish;
  end

  task automatic send_item(input logic op_i, input logic [BYTE_W-1:0] b,
                           input bit fixed, input result_t want);
    int gap;
    gap = (send_idle_on && !burst_on) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_i;
    rx_byte   <= b;
    row_fixed <= fixed;
    row_want  <= want;
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  task automatic wait_results_in();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one unit: a recenter, a stray byte, or a three-byte packet
  task automatic send_random_unit();
    int                pick;
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] xm;
    logic [BYTE_W-1:0] ym;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) drift_x = !drift_x;
    if ($urandom_range(0, 39) == 0) drift_y = !drift_y;
    if (pick < 8) begin
      send_item(OP_RECENTER, BYTE_W'($urandom), 1'b0, '0);
    end else if (pick < 20) begin
      send_item(OP_BYTE, BYTE_W'($urandom), 1'b0, '0);
    end else begin
      hdr = BYTE_W'($urandom);
      hdr[HDR_SYNC_BIT] = 1'b1;
      hdr[HDR_XOVF_BIT] = ($urandom_range(0, 9) == 0);
      hdr[HDR_YOVF_BIT] = ($urandom_range(0, 9) == 0);
      xm = BYTE_W'($urandom);
      ym = BYTE_W'($urandom);
      // large moves in a steady direction push the cursor into the clamps
      if ($urandom_range(0, 1) == 1) begin
        hdr[HDR_XSIGN_BIT] = drift_x;
        hdr[HDR_YSIGN_BIT] = drift_y;
        xm = drift_x ? BYTE_W'($urandom_range(0, 127)) : BYTE_W'($urandom_range(128, 255));
        ym = drift_y ? BYTE_W'($urandom_range(0, 127)) : BYTE_W'($urandom_range(128, 255));
      end
      send_item(OP_BYTE, hdr, 1'b0, '0);
      send_item(OP_BYTE, xm, 1'b0, '0);
      send_item(OP_BYTE, ym, 1'b0, '0);
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int                target;
    int                start;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    op           = OP_BYTE;
    rx_byte      = '0;
    row_fixed    = 1'b0;
    row_want     = '0;
    hold_req     = 1'b0;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    burst_on     = 1'b0;
    drift_x      = 1'b0;
    drift_y      = 1'b1;
    items_sent   = 0;
    fail_count   = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_item(dir_rows[i].op_v, dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].want);
    wait_results_in();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin w = 13'd32;   h = 13'd32;   end
        1:       begin w = 13'd4096; h = 13'd4096; end
        2:       begin w = 13'd32;   h = 13'd4096; end
        3:       begin w = 13'd4096; h = 13'd32;   end
        4:       begin w = 13'd1024; h = 13'd768;  end
        5:       begin w = 13'd33;   h = 13'd4095; end
        default: begin
          w = SIZE_W'($urandom_range(32, 4096));
          h = SIZE_W'($urandom_range(32, 4096));
        end
      endcase
      set_screen(w, h);
      send_idle_on = (ph % 4) < 2;
      recv_idle_on = (ph % 4) == 0 || (ph % 4) == 2;
      start  = items_sent;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (ph == 1 && items_sent >= start + 30 && items_sent < start + 33) begin
          // block the result side and keep offering until input backs up
          hold_req = 1'b1;
          burst_on = 1'b1;
          repeat (8) send_random_unit();
          burst_on = 1'b0;
        end else if (ph == 3 && items_sent >= start + 100 && items_sent < start + 103) begin
          wait_results_in();
          send_random_unit();
        end else begin
          send_random_unit();
        end
      end
      wait_results_in();
    end

    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("** ps2_mouse_packet_tracker_unit: PASSED **");
    else
      $display("** ps2_mouse_packet_tracker_unit: FAILED **");
    $finish;
  end

endmodule
